// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the fader pickup block
// no dependencies; the checks collapse to nothing in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
// implication checked in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== hw/rtl/fstp_pkg.sv =====
// types, codes and helpers of the fader soft-takeover pickup block
// no dependencies; imported by fader_soft_takeover_pickup
package fstp_pkg;

	localparam int VALUE_BITS  = 14;
	localparam int THRESH_BITS = 15;
	localparam int STATE_BITS  = 3;

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 15'd16;

	// opcode values
	localparam logic OP_HOST = 1'b0;
	localparam logic OP_HW   = 1'b1;

	// external pickup state codes
	localparam logic [STATE_BITS-1:0] CODE_RESET        = 3'd0;
	localparam logic [STATE_BITS-1:0] CODE_HW_UNKNOWN   = 3'd1;
	localparam logic [STATE_BITS-1:0] CODE_HOST_UNKNOWN = 3'd2;
	localparam logic [STATE_BITS-1:0] CODE_SYNCED       = 3'd3;
	localparam logic [STATE_BITS-1:0] CODE_TOO_HIGH     = 3'd4;
	localparam logic [STATE_BITS-1:0] CODE_TOO_LOW      = 3'd5;

	typedef logic [VALUE_BITS-1:0]  value_t;
	typedef logic [THRESH_BITS-1:0] thresh_t;

	typedef struct packed {
		logic   opcode;
		value_t level;
	} in_item_t;

	typedef struct packed {
		logic                  is_synced;
		logic [STATE_BITS-1:0] pickup_state;
	} out_item_t;

	// internal pickup state, one-hot
	typedef enum logic [5:0] {
		ST_RESET        = 6'b000001,
		ST_HW_UNKNOWN   = 6'b000010,
		ST_HOST_UNKNOWN = 6'b000100,
		ST_SYNCED       = 6'b001000,
		ST_TOO_HIGH     = 6'b010000,
		ST_TOO_LOW      = 6'b100000
	} pickup_st_t;

	// one-hot state to external code
	function automatic logic [STATE_BITS-1:0] state_code(input pickup_st_t st);
		logic [STATE_BITS-1:0] code;
		unique case (st)
			ST_HW_UNKNOWN:   code = CODE_HW_UNKNOWN;
			ST_HOST_UNKNOWN: code = CODE_HOST_UNKNOWN;
			ST_SYNCED:       code = CODE_SYNCED;
			ST_TOO_HIGH:     code = CODE_TOO_HIGH;
			ST_TOO_LOW:      code = CODE_TOO_LOW;
			default:         code = CODE_RESET;
		endcase
		return code;
	endfunction

endpackage

// ===== hw/rtl/fader_soft_takeover_pickup.sv =====
// top level of the fader soft-takeover pickup tracker
// depends on fstp_pkg and assert_macros.svh
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_ready, in_data      | input transactions
//  out     | out_valid, out_ready, out_data   | one result per input
//  cfg     | cfg_valid, cfg_ready, cfg_data   | sync threshold write
//
// each transaction passes through the input register, then the result register, from
// acceptance to result; one transaction per cycle sustained while out_ready is high.
// the pickup state and both positions update as a transaction leaves the input
// register, so a following transaction sees them at once.
// a stalled result holds the input register, which then holds in_ready low.
// reset: state reset, positions zero, threshold 16; cfg_ready is always high.
module fader_soft_takeover_pickup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fstp_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fstp_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  fstp_pkg::thresh_t    cfg_data
);
	import fstp_pkg::*;

	`include "assert_macros.svh"

	logic       valid_s1;
	in_item_t   item_s1;
	logic       advance;
	thresh_t    thresh_q;
	pickup_st_t mode_q;
	value_t     host_q;
	value_t     hw_q;
	out_item_t  result_q;
	logic       out_valid_q;

	value_t                 hw_new;
	value_t                 host_new;
	logic [VALUE_BITS:0]    diff;
	logic [VALUE_BITS:0]    mag;
	logic                   near;
	logic                   above;
	logic                   below;
	pickup_st_t             classify;
	pickup_st_t             mode_next;

	// handshake
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			thresh_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// signed difference hardware minus host, its magnitude and the compares
	always_comb begin
		hw_new   = (item_s1.opcode == OP_HW)   ? item_s1.level : hw_q;
		host_new = (item_s1.opcode == OP_HOST) ? item_s1.level : host_q;
		diff     = {1'b0, hw_new} - {1'b0, host_new};
		mag      = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;
		near     = mag < thresh_q;
		below    = diff[VALUE_BITS];
		above    = !diff[VALUE_BITS] && (diff != '0);
		classify = near ? ST_SYNCED : (above ? ST_TOO_HIGH : ST_TOO_LOW);
	end

	// next pickup state
	always_comb begin
		if (item_s1.opcode == OP_HOST) begin
			if (mode_q == ST_RESET || mode_q == ST_HW_UNKNOWN) begin
				mode_next = ST_HW_UNKNOWN;
			end else begin
				mode_next = classify;
			end
		end else begin
			unique case (mode_q)
				ST_RESET, ST_HOST_UNKNOWN: mode_next = ST_HOST_UNKNOWN;
				ST_SYNCED:                 mode_next = ST_SYNCED;
				ST_TOO_HIGH:               mode_next = (near || below) ? ST_SYNCED : ST_TOO_HIGH;
				ST_TOO_LOW:                mode_next = (near || above) ? ST_SYNCED : ST_TOO_LOW;
				ST_HW_UNKNOWN:             mode_next = classify;
				default:                   mode_next = ST_RESET;
			endcase
		end
	end

	// state and positions update as the transaction moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ST_RESET;
			host_q <= '0;
			hw_q   <= '0;
		end else if (valid_s1 && advance) begin
			mode_q <= mode_next;
			host_q <= host_new;
			hw_q   <= hw_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q.is_synced    <= (mode_next == ST_SYNCED);
			result_q.pickup_state <= state_code(mode_next);
		end
	end

	// checks
	`ASSERT_ALWAYS(a_synced_flag, clk, arst_n,
		!out_valid_q || (result_q.is_synced == (result_q.pickup_state == CODE_SYNCED)))
	`ASSERT_ALWAYS(a_result_tracks_state, clk, arst_n,
		!out_valid_q || (result_q.pickup_state == state_code(mode_q)))
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(item_s1))
	`ASSERT_NEXT(a_synced_sticks, clk, arst_n,
		valid_s1 && advance && mode_q == ST_SYNCED && item_s1.opcode == OP_HW,
		mode_q == ST_SYNCED)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the fader soft-takeover pickup tracker
// depends on fstp_pkg and fader_soft_takeover_pickup; a directed table, then random phases
module testbench;
	import fstp_pkg::*;

	// one row of the directed table; exp is used only where typed is set
	typedef struct packed {
		logic      op;
		value_t    val;
		logic      typed;
		out_item_t exp;
	} stim_row_t;

	localparam int ROWS = 24;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 66;
	localparam int IDLE_PCT = 37;
	localparam int VALUE_MAX = (1 << VALUE_BITS) - 1;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	thresh_t   cfg_data;

	// tracked copy of the block state and its threshold
	logic [STATE_BITS-1:0] mode_now;
	value_t                host_pos;
	value_t                hw_pos;
	thresh_t               threshold;

	out_item_t expected_pickups [$];
	int        mismatches;
	logic      steady;

	stim_row_t directed_rows [0:ROWS-1] = '{
		'{OP_HOST, 14'd0,     1'b1, '{1'b0, CODE_HW_UNKNOWN}},
		'{OP_HOST, 14'd16383, 1'b1, '{1'b0, CODE_HW_UNKNOWN}},
		'{OP_HW,   14'd0,     1'b1, '{1'b0, CODE_TOO_LOW}},
		'{OP_HW,   14'd100,   1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd16383, 1'b1, '{1'b1, CODE_SYNCED}},
		'{OP_HW,   14'd0,     1'b1, '{1'b1, CODE_SYNCED}},
		'{OP_HOST, 14'd16383, 1'b1, '{1'b0, CODE_TOO_LOW}},
		'{OP_HW,   14'd16370, 1'b0, '{1'b0, CODE_RESET}},
		'{OP_HOST, 14'd0,     1'b1, '{1'b0, CODE_TOO_HIGH}},
		'{OP_HW,   14'd8000,  1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd16,    1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd15,    1'b0, '{1'b0, CODE_RESET}},
		'{OP_HOST, 14'd31,    1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd16,    1'b0, '{1'b0, CODE_RESET}},
		'{OP_HOST, 14'd1000,  1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd5000,  1'b0, '{1'b0, CODE_RESET}},
		'{OP_HOST, 14'd16383, 1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd16383, 1'b0, '{1'b0, CODE_RESET}},
		'{OP_HOST, 14'd0,     1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd0,     1'b0, '{1'b0, CODE_RESET}},
		'{OP_HOST, 14'd5000,  1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd9000,  1'b0, '{1'b0, CODE_RESET}},
		'{OP_HOST, 14'd2000,  1'b0, '{1'b0, CODE_RESET}},
		'{OP_HW,   14'd1000,  1'b0, '{1'b0, CODE_RESET}}
	};

	fader_soft_takeover_pickup uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// overall limit on the run
	initial begin
		#(4_000_000);
		$display("testbench failed");
		$finish;
	end

	// both positions known: synced, too high or too low
	function automatic logic [STATE_BITS-1:0] classify_pair(int diff, int mag);
		if (mag < int'(threshold))
			return CODE_SYNCED;
		return (diff > 0) ? CODE_TOO_HIGH : CODE_TOO_LOW;
	endfunction

	// next pickup state and result for one accepted transaction
	function automatic out_item_t track_pickup(in_item_t it);
		int                    hw_next;
		int                    host_next;
		int                    diff;
		int                    mag;
		logic [STATE_BITS-1:0] nxt;
		out_item_t             res;
		hw_next   = (it.opcode == OP_HW) ? int'(it.level) : int'(hw_pos);
		host_next = (it.opcode == OP_HOST) ? int'(it.level) : int'(host_pos);
		diff      = hw_next - host_next;
		mag       = (diff < 0) ? -diff : diff;
		if (it.opcode == OP_HOST) begin
			if (mode_now == CODE_RESET || mode_now == CODE_HW_UNKNOWN)
				nxt = CODE_HW_UNKNOWN;
			else
				nxt = classify_pair(diff, mag);
			host_pos = it.level;
		end else begin
			case (mode_now)
				CODE_RESET, CODE_HOST_UNKNOWN: nxt = CODE_HOST_UNKNOWN;
				CODE_SYNCED:                   nxt = CODE_SYNCED;
				CODE_TOO_HIGH: begin
					nxt = (mag < int'(threshold) || diff < 0) ? CODE_SYNCED : CODE_TOO_HIGH;
				end
				CODE_TOO_LOW: begin
					nxt = (mag < int'(threshold) || diff > 0) ? CODE_SYNCED : CODE_TOO_LOW;
				end
				CODE_HW_UNKNOWN:               nxt = classify_pair(diff, mag);
				default:                       nxt = CODE_RESET;
			endcase
			hw_pos = it.level;
		end
		mode_now = nxt;
		res.is_synced    = (nxt == CODE_SYNCED);
		res.pickup_state = nxt;
		return res;
	endfunction

	// random position, often close to the other side or at the ends of travel
	function automatic value_t pick_position(logic op);
		int other;
		int pos;
		int r;
		other = (op == OP_HW) ? int'(host_pos) : int'(hw_pos);
		r = $urandom_range(99);
		if (r < 20) begin
			pos = other + $urandom_range(40) - 20;
		end else if (r < 35) begin
			// right at the threshold boundary on either side
			pos = other + (($urandom_range(1) != 0) ? 1 : -1)
				* (int'(threshold) - $urandom_range(1));
		end else if (r < 50) begin
			pos = ($urandom_range(1) != 0) ? VALUE_MAX : 0;
		end else begin
			pos = $urandom_range(VALUE_MAX);
		end
		if (pos < 0)
			pos = 0;
		if (pos > VALUE_MAX)
			pos = VALUE_MAX;
		return value_t'(pos);
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		mismatches++;
	endtask

	// present one transaction, wait for acceptance and record its expectation
	task automatic send_item(in_item_t it, logic typed, out_item_t typed_exp);
		out_item_t predicted;
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		predicted = track_pickup(it);
		expected_pickups.push_back(typed ? typed_exp : predicted);
	endtask

	// hold the sender until every result is back, then let the pipeline settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pickups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(thresh_t v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		threshold = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// result checking
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pickups.size() == 0) begin
				report_mismatch("unexpected result, state", -1, int'(out_data.pickup_state));
			end else begin
				want = expected_pickups.pop_front();
				if (out_data.is_synced !== want.is_synced)
					report_mismatch("is_synced", int'(want.is_synced), int'(out_data.is_synced));
				if (out_data.pickup_state !== want.pickup_state)
					report_mismatch("pickup_state", int'(want.pickup_state),
						int'(out_data.pickup_state));
			end
		end
	end

	// stimulus
	initial begin
		in_item_t  it;
		out_item_t none;
		thresh_t   phase_thresh [0:PHASES-1];
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		steady     = 1'b0;
		mismatches = 0;
		mode_now   = CODE_RESET;
		host_pos   = '0;
		hw_pos     = '0;
		threshold  = THRESH_RESET;
		none       = '0;
		phase_thresh[0] = THRESH_RESET;
		phase_thresh[1] = 15'd0;
		phase_thresh[2] = 15'd16384;
		phase_thresh[3] = 15'd1;
		phase_thresh[4] = thresh_t'($urandom_range(32767));
		phase_thresh[5] = 15'd32767;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table at the reset threshold
		for (int i = 0; i < ROWS; i++) begin
			it.opcode = directed_rows[i].op;
			it.level  = directed_rows[i].val;
			send_item(it, directed_rows[i].typed, directed_rows[i].exp);
		end

		// random phases, each under its own threshold
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				drain_results();
				write_threshold(phase_thresh[p]);
			end
			// one phase runs with no idling on either side
			steady = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it.opcode = ($urandom_range(99) < 70) ? OP_HW : OP_HOST;
				it.level  = pick_position(it.opcode);
				send_item(it, 1'b0, none);
			end
		end

		steady = 1'b0;
		drain_results();
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
